/* hw/rtl/chk_pkg.sv */
// Shared types, constants and word functions for the ChaCha keystream block generator.
// Used by every module under hw/rtl; depends on nothing else.
package chk_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned CtrW     = 64;
	localparam int unsigned OvfW     = 32;
	localparam int unsigned IdxW     = 4;
	localparam int unsigned NumWords = 16;
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned QueueDepthDef = 2;

	// Matrix constants, "expand 32-byte k" / "expand 16-byte k"
	localparam logic [WordW-1:0] Const0      = 32'h61707865;
	localparam logic [WordW-1:0] Const1Long  = 32'h3320646e;
	localparam logic [WordW-1:0] Const1Short = 32'h3120646e;
	localparam logic [WordW-1:0] Const2Long  = 32'h79622d32;
	localparam logic [WordW-1:0] Const2Short = 32'h79622d36;
	localparam logic [WordW-1:0] Const3      = 32'h6b206574;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegKey01   = 8'd0;
	localparam logic [CfgIdxW-1:0] RegKey23   = 8'd1;
	localparam logic [CfgIdxW-1:0] RegKey45   = 8'd2;
	localparam logic [CfgIdxW-1:0] RegKey67   = 8'd3;
	localparam logic [CfgIdxW-1:0] RegNonce   = 8'd4;
	localparam logic [CfgIdxW-1:0] RegRounds  = 8'd5;
	localparam logic [CfgIdxW-1:0] RegShort   = 8'd6;
	localparam logic [CfgIdxW-1:0] RegExtend  = 8'd7;

	localparam logic [7:0] RoundsReset = 8'd20;
	localparam logic [IdxW-1:0] LastIdx = 4'd15;

	typedef enum logic {
		OpGenerate = 1'b0,
		OpSetPos   = 1'b1
	} chk_op_t;

	typedef logic [WordW-1:0] word_t;
	typedef logic [NumWords-1:0][WordW-1:0] chk_block_t;

	typedef struct packed {
		logic [63:0] key01;
		logic [63:0] key23;
		logic [63:0] key45;
		logic [63:0] key67;
		logic [63:0] nonce;
		logic [7:0]  rounds;
		logic        short_key;
		logic        extend;
	} chk_cfg_t;

	typedef struct packed {
		logic [CtrW-1:0] counter;
		logic [OvfW-1:0] overflow;
	} chk_job_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} chk_quad_t;

	function automatic word_t rotl(word_t v, int unsigned r);
		return (v << r) | (v >> (WordW - r));
	endfunction

	// Half of a quarter round: first half rotates 16/12, second half 8/7
	function automatic chk_quad_t half_step(chk_quad_t q, logic second);
		chk_quad_t r;
		r = q;
		r.a = q.a + q.b;
		r.d = second ? rotl(q.d ^ r.a, 8) : rotl(q.d ^ r.a, 16);
		r.c = q.c + r.d;
		r.b = second ? rotl(q.b ^ r.c, 7) : rotl(q.b ^ r.c, 12);
		return r;
	endfunction

	// One word of the input matrix
	function automatic word_t matrix_word(chk_cfg_t cfg, logic [CtrW-1:0] ctr,
			logic [IdxW-1:0] idx);
		word_t w;
		case (idx)
			4'd0:  w = Const0;
			4'd1:  w = cfg.short_key ? Const1Short : Const1Long;
			4'd2:  w = cfg.short_key ? Const2Short : Const2Long;
			4'd3:  w = Const3;
			4'd4:  w = cfg.key01[31:0];
			4'd5:  w = cfg.key01[63:32];
			4'd6:  w = cfg.key23[31:0];
			4'd7:  w = cfg.key23[63:32];
			4'd8:  w = cfg.short_key ? cfg.key01[31:0]  : cfg.key45[31:0];
			4'd9:  w = cfg.short_key ? cfg.key01[63:32] : cfg.key45[63:32];
			4'd10: w = cfg.short_key ? cfg.key23[31:0]  : cfg.key67[31:0];
			4'd11: w = cfg.short_key ? cfg.key23[63:32] : cfg.key67[63:32];
			4'd12: w = ctr[31:0];
			4'd13: w = ctr[63:32];
			4'd14: w = cfg.nonce[31:0];
			default: w = cfg.nonce[63:32];
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/chk_front.sv */
// Front end: accepts request words, keeps block counter and overflow word, queues jobs.
// Depends on chk_pkg.
module chk_front import chk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	input  logic [CtrW-1:0] position,
	input  logic [OvfW-1:0] overflow,
	output logic            push_valid,
	input  logic            push_ready,
	output chk_job_t        push_job
);

	logic [CtrW-1:0] counter_q;
	logic [OvfW-1:0] ovf_q;
	logic            is_gen;
	logic            accept;

	assign is_gen     = (chk_op_t'(op) == OpGenerate);
	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && is_gen;
	assign push_job   = '{counter: counter_q, overflow: ovf_q};

	// Advance position after each generate, or load it on set-position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			ovf_q     <= '0;
		end else if (accept) begin
			if (is_gen) begin
				counter_q <= counter_q + 1'b1;
				if (&counter_q) ovf_q <= ovf_q + 1'b1;
			end else begin
				counter_q <= position;
				ovf_q     <= overflow;
			end
		end
	end

endmodule

/* hw/rtl/chk_queue.sv */
// Short job queue between the front end and the round core.
// Depends on chk_pkg.
module chk_queue import chk_pkg::*; #(
	parameter int unsigned Depth = QueueDepthDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  chk_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_ready,
	output chk_job_t pop_job
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	chk_job_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	// Store entry
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/chk_core.sv */
// Round core: builds the matrix for one job and runs the rounds, half a round per cycle.
// Depends on chk_pkg.
module chk_core import chk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chk_cfg_t   cfg,
	input  logic       job_valid,
	output logic       job_ready,
	input  chk_job_t   job,
	output logic       done_valid,
	input  logic       done_ready,
	output chk_block_t done_x,
	output chk_job_t   done_job
);

	typedef enum logic [2:0] {
		StIdle  = 3'b001,
		StRound = 3'b010,
		StHold  = 3'b100
	} chk_state_t;

	chk_state_t state_q;
	chk_block_t x_q;
	chk_block_t x_init;
	chk_block_t x_step;
	chk_job_t   job_q;
	logic [7:0] round_q;
	logic       half_q;
	logic       last_round;
	logic       diag;

	assign job_ready  = (state_q == StIdle);
	assign done_valid = (state_q == StHold);
	assign done_x     = x_q;
	assign done_job   = job_q;

	assign last_round = (round_q == cfg.rounds - 8'd1);
	// Odd rounds are diagonal; an odd count ends on an extra diagonal round
	assign diag = round_q[0] | (cfg.rounds[0] & last_round);

	// Build the starting matrix, overflow word mixed into word 0 when extend is set
	always_comb begin
		for (int i = 0; i < NumWords; i++) begin
			x_init[i] = matrix_word(cfg, job.counter, IdxW'(i));
		end
		if (cfg.extend) x_init[0] = x_init[0] + job.overflow;
	end

	// Apply one half round to all four lanes
	always_comb begin
		logic [IdxW-1:0] ib;
		logic [IdxW-1:0] ic;
		logic [IdxW-1:0] id;
		chk_quad_t       q;
		chk_quad_t       r;
		x_step = x_q;
		for (int j = 0; j < 4; j++) begin
			ib = IdxW'(4 + ((j + int'(diag)) & 3));
			ic = IdxW'(8 + ((j + 2 * int'(diag)) & 3));
			id = IdxW'(12 + ((j + 3 * int'(diag)) & 3));
			q = '{a: x_q[j], b: x_q[ib], c: x_q[ic], d: x_q[id]};
			r = half_step(q, half_q);
			x_step[j]  = r.a;
			x_step[ib] = r.b;
			x_step[ic] = r.c;
			x_step[id] = r.d;
		end
	end

	// Sequence load, rounds and handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			round_q <= '0;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (job_valid) begin
						round_q <= '0;
						half_q  <= 1'b0;
						state_q <= (cfg.rounds == '0) ? StHold : StRound;
					end
				end
				StRound: begin
					half_q <= ~half_q;
					if (half_q) begin
						round_q <= round_q + 8'd1;
						if (last_round) state_q <= StHold;
					end
				end
				StHold: begin
					if (done_ready) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Working matrix and job context
	always_ff @(posedge clk) begin
		if (state_q == StIdle && job_valid) begin
			x_q   <= x_init;
			job_q <= job;
		end else if (state_q == StRound) begin
			x_q <= x_step;
		end
	end

endmodule

/* hw/rtl/chk_drain.sv */
// Output stage: holds a finished block, adds the matrix back and sends one word per
// cycle unless out_ready stalls it. Depends on chk_pkg.
module chk_drain import chk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  chk_cfg_t        cfg,
	input  logic            load_valid,
	output logic            load_ready,
	input  chk_block_t      load_x,
	input  chk_job_t        load_job,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [WordW-1:0] out_word,
	output logic [IdxW-1:0] out_index,
	output logic            out_last
);

	chk_block_t      buf_q;
	chk_job_t        job_q;
	logic [IdxW-1:0] idx_q;
	logic            busy_q;
	logic            valid_q;
	logic [WordW-1:0] word_q;
	logic [IdxW-1:0] index_q;
	logic            last_q;
	logic            advance;
	logic [WordW-1:0] sum;

	// Take the next block while the last word of this one moves out
	assign load_ready = !busy_q || (advance && (idx_q == LastIdx));
	assign advance    = busy_q && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign out_word   = word_q;
	assign out_index  = index_q;
	assign out_last   = last_q;

	// Final addition of the input matrix, overflow again on word 0 when extend is set
	always_comb begin
		sum = buf_q[idx_q] + matrix_word(cfg, job_q.counter, idx_q);
		if (idx_q == '0 && cfg.extend) sum = sum + job_q.overflow;
	end

	// Track block occupancy and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load_valid && load_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LastIdx) busy_q <= 1'b0;
			end
			if (advance) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	// Hold block and output word
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			buf_q <= load_x;
			job_q <= load_job;
		end
		if (advance) begin
			word_q  <= sum;
			index_q <= idx_q;
			last_q  <= (idx_q == LastIdx);
		end
	end

endmodule

/* hw/rtl/chacha_keystream_block_generator.sv */
// Top level of the ChaCha keystream block generator: config registers and the
// front end / queue / round core / output stage chain. Depends on chk_pkg.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata position, overflow; tuser op
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata stream word, index; tlast
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A generate word runs in the round core half a round per cycle on one shared set of
// four lanes, and the output stage then sends its 16 output words.
// The core works on the next block while the output stage drains the previous one.
// A set-position word is absorbed by the front end and is not queued.
// Reset clears the counter, overflow word and registers to their reset values.
// Output stalls back up through the output stage, core and queue to s_axis_tready.
module chacha_keystream_block_generator import chk_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [95:0]         s_axis_tdata,  // new_position[63:0], new_overflow[95:64]
	input  logic [0:0]          s_axis_tuser,  // op[0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [39:0]         m_axis_tdata,  // stream_word[31:0], word_index[35:32], zero
	output logic                m_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [63:0]         cfg_data
);

	chk_cfg_t   cfg_q;
	logic       push_valid;
	logic       push_ready;
	chk_job_t   push_job;
	logic       pop_valid;
	logic       pop_ready;
	chk_job_t   pop_job;
	logic       done_valid;
	logic       done_ready;
	chk_block_t done_x;
	chk_job_t   done_job;
	logic [WordW-1:0] out_word;
	logic [IdxW-1:0]  out_index;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key01     <= '0;
			cfg_q.key23     <= '0;
			cfg_q.key45     <= '0;
			cfg_q.key67     <= '0;
			cfg_q.nonce     <= '0;
			cfg_q.rounds    <= RoundsReset;
			cfg_q.short_key <= 1'b0;
			cfg_q.extend    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegKey01:  cfg_q.key01     <= cfg_data;
				RegKey23:  cfg_q.key23     <= cfg_data;
				RegKey45:  cfg_q.key45     <= cfg_data;
				RegKey67:  cfg_q.key67     <= cfg_data;
				RegNonce:  cfg_q.nonce     <= cfg_data;
				RegRounds: cfg_q.rounds    <= cfg_data[7:0];
				RegShort:  cfg_q.short_key <= cfg_data[0];
				RegExtend: cfg_q.extend    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	chk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser[0]),
		.position   (s_axis_tdata[63:0]),
		.overflow   (s_axis_tdata[95:64]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	chk_queue #(.Depth(QueueDepth)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	chk_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job        (pop_job),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.done_x     (done_x),
		.done_job   (done_job)
	);

	chk_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.load_valid (done_valid),
		.load_ready (done_ready),
		.load_x     (done_x),
		.load_job   (done_job),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (out_word),
		.out_index  (out_index),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, out_index, out_word};

`ifndef NO_ASSERTIONS
	// Last flag sits on word fifteen only
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[35:32] == LastIdx)))
		else $error("tlast does not match word index");

	// Words of a block come out in order
	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
		|-> m_axis_tdata[35:32] == $past(m_axis_tdata[35:32]) + 4'd1)
		else $error("word index skipped");

	// Finished block waits in the core until the output stage takes it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done_valid && !done_ready) |=> (done_valid && $stable(done_job)))
		else $error("finished block dropped");
`endif

endmodule

/* tb/chacha_keystream_block_generator_tb.sv */
// Self-checking testbench for chacha_keystream_block_generator: random and directed
// block requests, register settings and handshake idling. Depends on chk_pkg.
// Expected keystream words come from an independent ChaCha block predictor.
module chacha_keystream_block_generator_tb;
	import chk_pkg::*;

	localparam int StallLimit  = 20000;
	localparam int DrainCycles = 600;
	localparam int RandomItems = 33;
	localparam int MaxReports  = 20;

	// Matrix constants, "expand 32-byte k" and its 16-byte variant
	localparam logic [31:0] SigmaA      = 32'h61707865;
	localparam logic [31:0] SigmaBLong  = 32'h3320646e;
	localparam logic [31:0] SigmaBShort = 32'h3120646e;
	localparam logic [31:0] SigmaCLong  = 32'h79622d32;
	localparam logic [31:0] SigmaCShort = 32'h79622d36;
	localparam logic [31:0] SigmaD      = 32'h6b206574;

	// Index with no register behind it
	localparam logic [CfgIdxW-1:0] RegUnmapped = 8'hA5;

	typedef struct {
		chk_op_t     op;
		logic [63:0] position;
		logic [31:0] overflow;
	} block_request_t;

	typedef struct {
		logic [31:0] word;
		logic [3:0]  index;
		logic        last;
	} keystream_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [95:0]        s_axis_tdata = '0;  // new_position[63:0], new_overflow[95:64]
	logic [0:0]         s_axis_tuser = '0;  // op[0]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [39:0]        m_axis_tdata;       // stream_word[31:0], word_index[35:32], zero
	logic               m_axis_tlast;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [63:0]        cfg_data = '0;

	// Shadow copy of the registers and the block position
	logic [63:0] key01, key23, key45, key67, nonce_val;
	logic [7:0]  round_count;
	logic        short_key;
	logic        mix_overflow;
	logic [63:0] block_counter;
	logic [31:0] overflow_count;
	logic [31:0] mix_words [16];

	block_request_t  request_queue [$];
	keystream_word_t keystream_expected [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int words_checked = 0;
	int blocks_predicted = 0;
	int positions_loaded = 0;
	int register_writes = 0;
	int idle_cycles = 0;

	chacha_keystream_block_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void mix_quarter(input int a, input int b, input int c, input int d);
		mix_words[a] = mix_words[a] + mix_words[b];
		mix_words[d] = rol32(mix_words[d] ^ mix_words[a], 16);
		mix_words[c] = mix_words[c] + mix_words[d];
		mix_words[b] = rol32(mix_words[b] ^ mix_words[c], 12);
		mix_words[a] = mix_words[a] + mix_words[b];
		mix_words[d] = rol32(mix_words[d] ^ mix_words[a], 8);
		mix_words[c] = mix_words[c] + mix_words[d];
		mix_words[b] = rol32(mix_words[b] ^ mix_words[c], 7);
	endfunction

	function automatic void mix_diagonals();
		mix_quarter(0, 5, 10, 15);
		mix_quarter(1, 6, 11, 12);
		mix_quarter(2, 7, 8, 13);
		mix_quarter(3, 4, 9, 14);
	endfunction

	// Build the block at the current position, queue its 16 words, then advance
	task automatic compute_keystream_block();
		logic [31:0] matrix [16];
		logic [31:0] key [8];
		keystream_word_t kw;
		int i;
		key[0] = key01[31:0]; key[1] = key01[63:32];
		key[2] = key23[31:0]; key[3] = key23[63:32];
		key[4] = key45[31:0]; key[5] = key45[63:32];
		key[6] = key67[31:0]; key[7] = key67[63:32];
		matrix[0] = SigmaA;
		matrix[1] = short_key ? SigmaBShort : SigmaBLong;
		matrix[2] = short_key ? SigmaCShort : SigmaCLong;
		matrix[3] = SigmaD;
		for (i = 0; i < 8; i++)
			matrix[4 + i] = short_key ? key[i % 4] : key[i];
		matrix[12] = block_counter[31:0];
		matrix[13] = block_counter[63:32];
		matrix[14] = nonce_val[31:0];
		matrix[15] = nonce_val[63:32];
		for (i = 0; i < 16; i++)
			mix_words[i] = matrix[i];
		if (mix_overflow)
			mix_words[0] = mix_words[0] + overflow_count;
		for (i = 0; i < int'(round_count) / 2; i++) begin
			mix_quarter(0, 4, 8, 12);
			mix_quarter(1, 5, 9, 13);
			mix_quarter(2, 6, 10, 14);
			mix_quarter(3, 7, 11, 15);
			mix_diagonals();
		end
		if (round_count[0])
			mix_diagonals();
		for (i = 0; i < 16; i++) begin
			kw.word = mix_words[i] + matrix[i];
			if (i == 0 && mix_overflow)
				kw.word = kw.word + overflow_count;
			kw.index = i[3:0];
			kw.last = (i == 15);
			keystream_expected.push_back(kw);
		end
		block_counter = block_counter + 64'd1;
		if (block_counter == 64'd0)
			overflow_count = overflow_count + 32'd1;
		blocks_predicted++;
	endtask

	task automatic apply_request(input block_request_t req);
		if (req.op == OpSetPos) begin
			block_counter = req.position;
			overflow_count = req.overflow;
			positions_loaded++;
		end else begin
			compute_keystream_block();
		end
	endtask

	// Request driver: retire the accepted word, then hold, present the next or idle
	always @(posedge clk) begin : drive_requests
		logic took;
		took = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(request_queue.pop_front());
				took = 1'b1;
			end
			if (s_axis_tvalid && !took) begin
				// hold the word on the bus until accepted
			end else if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {request_queue[0].overflow, request_queue[0].position};
				s_axis_tuser <= request_queue[0].op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Keystream monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin : check_keystream
		keystream_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (keystream_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports)
						$display("%0t: expected no word, actual word %h index %0d last %b",
							$time, m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
				end else begin
					want = keystream_expected.pop_front();
					words_checked++;
					if (m_axis_tdata[31:0] !== want.word || m_axis_tdata[35:32] !== want.index ||
							m_axis_tlast !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= MaxReports)
							$display("%0t: expected %h/%0d/%b, actual %h/%0d/%b",
								$time, want.word, want.index, want.last,
								m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when no channel moves a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= StallLimit) begin
				$display("%0t: no progress for %0d cycles", $time, StallLimit);
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegKey01:  key01 = data;
			RegKey23:  key23 = data;
			RegKey45:  key45 = data;
			RegKey67:  key67 = data;
			RegNonce:  nonce_val = data;
			RegRounds: round_count = data[7:0];
			RegShort:  short_key = data[0];
			RegExtend: mix_overflow = data[0];
			default: ;
		endcase
		register_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_generate();
		block_request_t req;
		req.op = OpGenerate;
		req.position = {$urandom, $urandom};
		req.overflow = $urandom;
		request_queue.push_back(req);
	endtask

	task automatic queue_position(input logic [63:0] pos, input logic [31:0] ovf);
		block_request_t req;
		req.op = OpSetPos;
		req.position = pos;
		req.overflow = ovf;
		request_queue.push_back(req);
	endtask

	// Wait for every request and expected word to clear, then let the core go quiet
	task automatic drain();
		while (request_queue.size() != 0 || keystream_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic randomize_registers();
		logic [63:0] data;
		write_register(RegKey01, {$urandom, $urandom});
		write_register(RegKey23, {$urandom, $urandom});
		write_register(RegKey45, {$urandom, $urandom});
		write_register(RegKey67, {$urandom, $urandom});
		write_register(RegNonce, {$urandom, $urandom});
		data = {$urandom, $urandom};
		data[7:0] = ($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(24, 1));
		write_register(RegRounds, data);
		write_register(RegShort, {$urandom, $urandom});
		write_register(RegExtend, {$urandom, $urandom});
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int n;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		randomize_registers();
		for (n = 0; n < RandomItems; n++) begin
			if ($urandom_range(3) != 0)
				queue_generate();
			else if ($urandom_range(1) == 0)
				queue_position(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3),
					($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
			else
				queue_position({$urandom, $urandom}, $urandom);
		end
		drain();
	endtask

	initial begin
		key01 = '0; key23 = '0; key45 = '0; key67 = '0; nonce_val = '0;
		round_count = RoundsReset;
		short_key = 1'b0;
		mix_overflow = 1'b1;
		block_counter = '0;
		overflow_count = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: first blocks, counter and overflow wrap, reload to zero
		queue_generate();
		queue_generate();
		queue_position(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_generate();
		queue_generate();
		queue_position(64'h0, 32'h0);
		queue_generate();
		drain();

		// All-ones key and nonce, most rounds, overflow mixed into word 0
		write_register(RegKey01, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(RegKey23, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(RegKey45, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(RegKey67, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(RegNonce, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(RegRounds, 64'd255);
		write_register(RegShort, 64'd0);
		write_register(RegExtend, 64'd1);
		queue_position(64'hFFFF_FFFF_FFFF_FFFE, 32'h8000_0001);
		queue_generate();
		queue_generate();
		queue_generate();
		drain();

		// No rounds at all, short key, no overflow term; unmapped index is ignored
		write_register(RegRounds, 64'd0);
		write_register(RegShort, 64'd1);
		write_register(RegExtend, 64'd0);
		write_register(RegKey01, {$urandom, $urandom});
		write_register(RegUnmapped, {$urandom, $urandom});
		queue_generate();
		queue_position({$urandom, $urandom}, $urandom);
		queue_generate();
		drain();

		// Single diagonal round with the overflow term
		write_register(RegRounds, 64'd1);
		write_register(RegExtend, 64'd1);
		queue_position({$urandom, $urandom}, 32'hFFFF_FFFF);
		queue_generate();
		queue_generate();
		drain();

		// One column/diagonal pair, long key
		write_register(RegRounds, 64'd2);
		write_register(RegShort, 64'd0);
		queue_generate();
		drain();

		run_random_phase(0, 0);
		run_random_phase(52, 0);
		run_random_phase(0, 52);
		run_random_phase(33, 33);

		$display("Covered %0d blocks (%0d words checked), %0d position loads, %0d register writes,",
			blocks_predicted, words_checked, positions_loaded, register_writes);
		$display("round counts 0 to 255, both key sizes, counter wraps and four idling mixes.");
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/chk_pkg.sv
hw/rtl/chk_front.sv
hw/rtl/chk_queue.sv
hw/rtl/chk_core.sv
hw/rtl/chk_drain.sv
hw/rtl/chacha_keystream_block_generator.sv
tb/chacha_keystream_block_generator_tb.sv
